// ----- sv/rms_pkg.sv -----
// rms_pkg: shared types and constants of the rate monotonic scheduler
// no dependencies; imported by the interfaces, the register block and the top level

package rms_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 16;

  localparam int CMD_W       = 1;
  localparam int TASK_IDX_W  = 4;
  localparam int TIME_FLD_W  = 16;
  localparam int COUNT_W     = 5;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CMD_W-1:0]   CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0]   CMD_TICK = 1'b1;

  // register index taken from paddr[2]
  localparam logic               REG_TASK_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] TASK_COUNT_RST = 5'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_REL,
    ST_DONE
  } state_t;

endpackage

// ----- sv/rms_if.sv -----
// rms_in_if / rms_out_if: valid-ready channels for command words and result words
// depends on rms_pkg for field widths

interface rms_in_if;
  import rms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [TASK_IDX_W-1:0] task_index;
  logic [TIME_FLD_W-1:0] exec_time;
  logic [TIME_FLD_W-1:0] task_period;

  modport source (output valid, command, task_index, exec_time, task_period, input ready);
  modport sink   (input valid, command, task_index, exec_time, task_period, output ready);
endinterface

interface rms_out_if;
  import rms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  ran;
  logic [TASK_IDX_W-1:0] running_task;

  modport source (output valid, ran, running_task, input ready);
  modport sink   (input valid, ran, running_task, output ready);
endinterface

// ----- sv/rms_cfg.sv -----
// rms_cfg: apb-style register block holding task_count
// depends on rms_pkg

module rms_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rms_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rms_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [rms_pkg::COUNT_W-1:0]    task_count
);
  import rms_pkg::*;

  logic [COUNT_W-1:0] task_count_r;
  logic [COUNT_W-1:0] task_count_nxt;
  logic               wr_hit;

  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TASK_COUNT);

  always_comb begin
    task_count_nxt = task_count_r;
    if (wr_hit) begin
      task_count_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TASK_COUNT_RST;
    end else begin
      task_count_r <= task_count_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TASK_COUNT) begin
      prdata = CFG_DATA_W'(task_count_r);
    end
  end

  assign pready     = 1'b1;
  assign task_count = task_count_r;

endmodule

// ----- sv/rate_monotonic_scheduler.sv -----
// rate_monotonic_scheduler: task table in one synchronous memory, select pass then release pass
// load word: entry written on accept, result loaded in ST_DONE once the output is free;
// tick word: ST_SEL then ST_REL read pass over the active entries, result loaded in ST_DONE
// one word in work at a time; the next word is taken while a result still waits at the output
// rst_n synchronous active low: entry valid bits cleared, task_count = 1, no clearing pass
// depends on rms_pkg, rms_in_if, rms_out_if, rms_cfg

module rate_monotonic_scheduler #(
  parameter int MAX_TASKS  = rms_pkg::MAX_TASKS_DEF,
  parameter int TIME_WIDTH = rms_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rms_in_if.sink                         in_bus,
  rms_out_if.source                      out_bus,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rms_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rms_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rms_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TW    = TIME_WIDTH;
  localparam int WORD_W = 4 * TW;

  logic [COUNT_W-1:0] task_count;
  logic [CNT_W-1:0]   n_eff;

  rms_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .task_count (task_count)
  );

  always_comb begin
    if (32'(task_count) > MAX_TASKS) begin
      n_eff = CNT_W'(MAX_TASKS);
    end else begin
      n_eff = CNT_W'(task_count);
    end
  end

  // task table: exec, period, remaining work, release countdown
  logic [WORD_W-1:0] mem [MAX_TASKS];
  logic [WORD_W-1:0] rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  rd_addr;
  logic [MAX_TASKS-1:0] valid_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             rv_r, rv_nxt;
  logic [IDX_W-1:0] rv_idx_r, rv_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [TW-1:0]    best_r, best_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ran_r;
  logic [TASK_IDX_W-1:0] out_task_r;

  logic in_fire, is_load, load_ok, issue, last_issued, out_free, out_load;

  logic [TW-1:0] f_exec, f_per, f_rem, f_cd, new_rem, new_cd;
  logic          rv_valid;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign is_load  = in_bus.command == CMD_LOAD;
  assign load_ok  = 32'(in_bus.task_index) < MAX_TASKS;
  assign out_free = !out_valid_r || out_bus.ready;
  assign last_issued = !(k_r < n_eff);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = is_load ? ST_DONE : ST_SEL;
        end
      end
      ST_SEL: begin
        if (last_issued && !rv_r) begin
          state_nxt = ST_REL;
        end
      end
      ST_REL: begin
        if (last_issued && !rv_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_bus.ready = 1'b0;
    issue        = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: in_bus.ready = 1'b1;
      ST_SEL:  issue = !last_issued;
      ST_REL:  issue = !last_issued;
      ST_DONE: out_load = out_free;
      default: in_bus.ready = 1'b0;
    endcase
  end

  assign rd_addr  = k_r[IDX_W-1:0];
  assign rv_valid = valid_r[rv_idx_r];

  // unpack returned entry; an unloaded entry reads with no work and expired countdown
  always_comb begin
    f_exec = rd_data_r[4*TW-1:3*TW];
    f_per  = rd_data_r[3*TW-1:2*TW];
    f_rem  = rv_valid ? rd_data_r[2*TW-1:TW] : '0;
    f_cd   = rv_valid ? rd_data_r[TW-1:0] : '0;
  end

  // release pass update
  always_comb begin
    new_rem = f_rem;
    new_cd  = f_cd;
    if (found_r && (rv_idx_r == pick_r)) begin
      new_rem = f_rem - TW'(1);
    end
    if (f_cd <= TW'(1)) begin
      new_rem = f_exec;
      new_cd  = f_per;
    end else begin
      new_cd = f_cd - TW'(1);
    end
  end

  // datapath next values and memory write port
  always_comb begin
    k_nxt      = k_r;
    rv_nxt     = issue;
    rv_idx_nxt = rd_addr;
    found_nxt  = found_r;
    pick_nxt   = pick_r;
    best_nxt   = best_r;
    mem_we     = 1'b0;
    mem_waddr  = rv_idx_r;
    mem_wdata  = {f_exec, f_per, new_rem, new_cd};
    if (issue) begin
      k_nxt = k_r + CNT_W'(1);
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          k_nxt     = '0;
          found_nxt = 1'b0;
          pick_nxt  = '0;
          if (is_load && load_ok) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(in_bus.task_index);
            mem_wdata = {TW'(in_bus.exec_time), TW'(in_bus.task_period),
                         TW'(in_bus.exec_time), TW'(in_bus.task_period)};
          end
        end
      end
      ST_SEL: begin
        if (rv_r && (f_rem != '0) && (!found_r || (f_per < best_r))) begin
          found_nxt = 1'b1;
          pick_nxt  = rv_idx_r;
          best_nxt  = f_per;
        end
        if (last_issued && !rv_r) begin
          k_nxt = '0;
        end
      end
      ST_REL: begin
        mem_we = rv_r && rv_valid;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (in_fire && is_load && load_ok) begin
      valid_r[IDX_W'(in_bus.task_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rv_idx_r <= rv_idx_nxt;
    pick_r   <= pick_nxt;
    best_r   <= best_nxt;
    if (out_load) begin
      out_ran_r  <= found_r;
      out_task_r <= found_r ? TASK_IDX_W'(pick_r) : '0;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.ran          = out_ran_r;
  assign out_bus.running_task = out_task_r;

  a_no_read_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rv_r)
    else $error("read in flight while idle");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL && found_r) |-> (32'(pick_r) < 32'(n_eff)))
    else $error("selected task outside active range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside done state");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(k_r) <= MAX_TASKS)
    else $error("scan counter past table depth");

endmodule
